// File: design/cor_pkg.sv
package cor_pkg;

  // Default sizes of the input fields
  localparam int RADIUS_BITS_DEF = 6;
  localparam int COORD_BITS_DEF  = 10;

  // Fixed result sizes
  localparam int OUT_W       = 12;
  localparam int NUM_COORDS  = 8;
  localparam int MAX_RESULTS = 64;
  // Holds 0..MAX_RESULTS for the small offset and the step count
  localparam int STEP_W      = $clog2(MAX_RESULTS + 1);

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RUN
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;  // take a new circle
    logic step;  // emit one octant step and advance
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last;  // the step now pending is the final one of the circle
  } sts_t;

endpackage

// File: design/circle_outline_rasterizer_top.sv
// Midpoint circle rasterizer, first octant walk.
//
// Slave stream: one request per circle in s_axis_tdata_i (center x, center y,
// radius). Master stream: one result per octant step with eight coordinates
// (center +- small and large offset, 12-bit two's complement, wrapping) and
// tlast on the final step of the circle.
//
// A circle is loaded on accept, then the walk gives one result per cycle while
// the receiver takes them, held in a single output register. A circle of radius r
// gives about 0.71*r + 1 results, at most 64. The walk loop does one decision
// update per cycle when the receiver does not stall; the next circle can be
// accepted in the cycle after the final step is issued, even while that result
// still waits in the register.
//
// Receiver stall: the walk pauses with the pending result held until it is
// taken. Reset clears the walk and the output valid; the block comes out of
// reset idle and ready for a circle.
module circle_outline_rasterizer_top #(
  parameter int RADIUS_BITS = cor_pkg::RADIUS_BITS_DEF,
  parameter int COORD_BITS  = cor_pkg::COORD_BITS_DEF,
  localparam int InW  = ((2 * COORD_BITS + RADIUS_BITS + 7) / 8) * 8,
  localparam int OutW = cor_pkg::NUM_COORDS * cor_pkg::OUT_W
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  // center_x, center_y, radius, zero pad
  input  logic [InW-1:0]  s_axis_tdata_i,
  output logic            m_axis_tvalid_o,
  input  logic            m_axis_tready_i,
  // x_plus_a, x_minus_a, x_plus_b, x_minus_b,
  // y_plus_a, y_minus_a, y_plus_b, y_minus_b
  output logic [OutW-1:0] m_axis_tdata_o,
  // last_step
  output logic            m_axis_tlast_o
);

  cor_pkg::cmd_t cmd;
  cor_pkg::sts_t sts;

  cor_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .cmd_o     (cmd),
    .sts_i     (sts)
  );

  cor_datapath #(
    .RADIUS_BITS (RADIUS_BITS),
    .COORD_BITS  (COORD_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .center_x_i  (s_axis_tdata_i[COORD_BITS-1:0]),
    .center_y_i  (s_axis_tdata_i[2*COORD_BITS-1:COORD_BITS]),
    .radius_i    (s_axis_tdata_i[2*COORD_BITS+RADIUS_BITS-1:2*COORD_BITS]),
    .coords_o    (m_axis_tdata_o),
    .last_step_o (m_axis_tlast_o)
  );

endmodule

// File: design/cor_ctrl.sv
module cor_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_valid_i,
  output logic          s_ready_o,
  output logic          m_valid_o,
  input  logic          m_ready_i,
  output cor_pkg::cmd_t cmd_o,
  input  cor_pkg::sts_t sts_i
);

  cor_pkg::state_e state_q, state_d;
  logic            m_valid_q, m_valid_d;
  logic            out_free;

  // Output slot is free when empty or being drained this cycle
  assign out_free = !m_valid_q || m_ready_i;

  // Command and handshake outputs
  always_comb begin
    cmd_o.load = 1'b0;
    cmd_o.step = 1'b0;
    s_ready_o  = 1'b0;
    unique case (state_q)
      cor_pkg::ST_IDLE: begin
        s_ready_o  = 1'b1;
        cmd_o.load = s_valid_i;
      end
      cor_pkg::ST_RUN: begin
        cmd_o.step = out_free;
      end
      default: begin
        s_ready_o = 1'b0;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cor_pkg::ST_IDLE: begin
        if (s_valid_i) begin
          state_d = cor_pkg::ST_RUN;
        end
      end
      cor_pkg::ST_RUN: begin
        if (out_free && sts_i.last) begin
          state_d = cor_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cor_pkg::ST_IDLE;
      end
    endcase
  end

  // Output register valid flag
  always_comb begin
    m_valid_d = m_valid_q;
    if (cmd_o.step) begin
      m_valid_d = 1'b1;
    end else if (m_ready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= cor_pkg::ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  assign m_valid_o = m_valid_q;

`ifndef SYNTHESIS
  // A new circle always starts a walk
  a_load_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == cor_pkg::ST_RUN)
    else $error("load did not start a walk");

  // Final step ends the walk
  a_last_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step && sts_i.last |=> state_q == cor_pkg::ST_IDLE)
    else $error("walk continued past final step");

  // A step never overwrites a result still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step |-> (!m_valid_q || m_ready_i))
    else $error("step overwrote pending result");

  // Input is never taken while a walk runs
  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == cor_pkg::ST_RUN |-> !s_ready_o && !cmd_o.load)
    else $error("input taken during walk");
`endif

endmodule

// File: design/cor_datapath.sv
module cor_datapath #(
  parameter int RADIUS_BITS = cor_pkg::RADIUS_BITS_DEF,
  parameter int COORD_BITS  = cor_pkg::COORD_BITS_DEF
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  cor_pkg::cmd_t                              cmd_i,
  output cor_pkg::sts_t                              sts_o,
  input  logic [COORD_BITS-1:0]                      center_x_i,
  input  logic [COORD_BITS-1:0]                      center_y_i,
  input  logic [RADIUS_BITS-1:0]                     radius_i,
  output logic [cor_pkg::NUM_COORDS*cor_pkg::OUT_W-1:0] coords_o,
  output logic                                       last_step_o
);

  localparam int OW   = cor_pkg::OUT_W;
  localparam int SW   = cor_pkg::STEP_W;
  // Signed width for offsets and the decision value
  localparam int BASE = (RADIUS_BITS > SW) ? RADIUS_BITS : SW;
  localparam int DW   = BASE + 5;

  logic [COORD_BITS-1:0]     cx_q, cy_q;
  logic [SW-1:0]             a_q;
  logic signed [RADIUS_BITS:0] b_q;
  logic signed [DW-1:0]      d_q;
  logic [SW-1:0]             n_q;

  logic signed [DW-1:0] a_s, b_s, na_s, nb_s, nd_s;
  logic                 last;
  logic [OW-1:0]        wx, wy, wa, wb;

  logic [OW-1:0] x_pa_q, x_ma_q, x_pb_q, x_mb_q;
  logic [OW-1:0] y_pa_q, y_ma_q, y_pb_q, y_mb_q;
  logic          last_q;

  // Next walk values from the current offsets
  always_comb begin
    a_s = DW'(a_q);
    b_s = DW'(b_q);
    if (d_q > 0) begin
      nd_s = d_q + ((a_s - b_s) <<< 2) + DW'(10);
      nb_s = b_s - DW'(1);
    end else begin
      nd_s = d_q + (a_s <<< 2) + DW'(6);
      nb_s = b_s;
    end
    na_s = a_s + DW'(1);
    last = (nb_s < na_s) || (n_q == SW'(cor_pkg::MAX_RESULTS - 1));
  end

  assign sts_o.last = last;

  // Coordinates wrap modulo the output width
  assign wx = OW'(cx_q);
  assign wy = OW'(cy_q);
  assign wa = OW'(a_q);
  assign wb = OW'(b_q[RADIUS_BITS-1:0]);

  // Walk registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= '0;
      cy_q <= '0;
      a_q  <= '0;
      b_q  <= '0;
      d_q  <= '0;
      n_q  <= '0;
    end else if (cmd_i.load) begin
      cx_q <= center_x_i;
      cy_q <= center_y_i;
      a_q  <= '0;
      b_q  <= {1'b0, radius_i};
      d_q  <= DW'(3) - (DW'(radius_i) <<< 1);
      n_q  <= '0;
    end else if (cmd_i.step) begin
      a_q <= na_s[SW-1:0];
      b_q <= nb_s[RADIUS_BITS:0];
      d_q <= nd_s;
      n_q <= n_q + SW'(1);
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      x_pa_q <= wx + wa;
      x_ma_q <= wx - wa;
      x_pb_q <= wx + wb;
      x_mb_q <= wx - wb;
      y_pa_q <= wy + wa;
      y_ma_q <= wy - wa;
      y_pb_q <= wy + wb;
      y_mb_q <= wy - wb;
      last_q <= last;
    end
  end

  assign coords_o = {y_mb_q, y_pb_q, y_ma_q, y_pa_q, x_mb_q, x_pb_q, x_ma_q, x_pa_q};
  assign last_step_o = last_q;

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int InW         = 32;
  localparam int OutW        = cor_pkg::NUM_COORDS * cor_pkg::OUT_W;
  localparam int StuckLimit  = 2000;
  localparam int RandomItems = 210;
  localparam int SettleCycles = 60;

  // One octant step: coords[0] sits in the lowest bits, as on m_axis_tdata
  typedef struct packed {
    logic                                              last;
    logic [cor_pkg::NUM_COORDS-1:0][cor_pkg::OUT_W-1:0] coords;
  } octant_step_t;

  function automatic string coord_name(int idx);
    case (idx)
      0: return "x_plus_a";
      1: return "x_minus_a";
      2: return "x_plus_b";
      3: return "x_minus_b";
      4: return "y_plus_a";
      5: return "y_minus_a";
      6: return "y_plus_b";
      default: return "y_minus_b";
    endcase
  endfunction

  // Walks each accepted circle and holds the octant steps still owed
  class circle_scoreboard;
    octant_step_t steps_q[$];
    int unsigned  errors;
    int unsigned  reported;

    function void report(string msg);
      errors++;
      if (reported < 10) begin
        reported++;
        $display("[%0t] mismatch: %s", $time, msg);
      end
    endfunction

    function int pending();
      return steps_q.size();
    endfunction

    // Midpoint walk; updates use a and b from before the step
    function void note_circle(logic [9:0] cx, logic [9:0] cy, logic [5:0] radius);
      int           cxi, cyi, a, b, d, na, nb, nd, n;
      octant_step_t s;
      cxi = cx;
      cyi = cy;
      a   = 0;
      b   = radius;
      d   = 3 - 2 * b;
      n   = 0;
      while (b >= a && n < cor_pkg::MAX_RESULTS) begin
        if (d > 0) begin
          nd = d + 4 * (a - b) + 10;
          nb = b - 1;
        end else begin
          nd = d + 4 * a + 6;
          nb = b;
        end
        na = a + 1;
        // coordinates wrap to 12-bit two's complement
        s.coords[0] = 12'(cxi + a);
        s.coords[1] = 12'(cxi - a);
        s.coords[2] = 12'(cxi + b);
        s.coords[3] = 12'(cxi - b);
        s.coords[4] = 12'(cyi + a);
        s.coords[5] = 12'(cyi - a);
        s.coords[6] = 12'(cyi + b);
        s.coords[7] = 12'(cyi - b);
        s.last      = !(nb >= na) || (n + 1 == cor_pkg::MAX_RESULTS);
        steps_q.push_back(s);
        n++;
        a = na;
        b = nb;
        d = nd;
      end
    endfunction

    function void check_step(logic [OutW-1:0] data, logic last);
      octant_step_t                                       want;
      logic [cor_pkg::NUM_COORDS-1:0][cor_pkg::OUT_W-1:0] got;
      got = data;
      if (steps_q.size() == 0) begin
        report($sformatf("result with nothing outstanding, tlast=%0b", last));
        return;
      end
      want = steps_q.pop_front();
      for (int i = 0; i < cor_pkg::NUM_COORDS; i++) begin
        if (got[i] !== want.coords[i]) begin
          report($sformatf("%s expected %0d, got %0d", coord_name(i),
                           $signed(want.coords[i]), $signed(got[i])));
        end
      end
      if (last !== want.last) begin
        report($sformatf("last_step expected %0b, got %0b", want.last, last));
      end
    endfunction
  endclass

  logic           clk_i;
  logic           rst_n   = 1'b0;
  logic           s_valid = 1'b0;
  logic [InW-1:0] s_data  = '0;
  logic           m_ready = 1'b0;
  logic           steady  = 1'b0;
  int             stall_left   = 0;
  int             stuck_cycles = 0;

  wire            s_axis_tready_o;
  wire            m_axis_tvalid_o;
  wire [OutW-1:0] m_axis_tdata_o;
  wire            m_axis_tlast_o;

  circle_scoreboard sb = new();

  circle_outline_rasterizer_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Idle length: mostly short, now and then long
  function automatic int idle_len();
    if ($urandom_range(0, 99) < 88) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Receiver back-pressure
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      m_ready    <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!steady && $urandom_range(0, 99) < 25) begin
      m_ready    <= 1'b0;
      stall_left <= idle_len() - 1;
    end else begin
      m_ready <= 1'b1;
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_n && m_axis_tvalid_o && m_ready) begin
      sb.check_step(m_axis_tdata_o, m_axis_tlast_o);
    end
  end

  // Watchdog on cycles with no transfer on either side
  always @(posedge clk_i) begin
    if ((s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= StuckLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Present one circle request and wait for it to be taken
  task automatic send_circle(input logic [9:0] cx, input logic [9:0] cy,
                             input logic [5:0] radius);
    int gap;
    gap = (steady || $urandom_range(0, 99) < 55) ? 0 : idle_len();
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {6'b0, radius, cy, cx};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_circle(cx, cy, radius);
  endtask

  // Hold the sender off until every owed step has come out
  task automatic drain();
    s_valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  function automatic logic [9:0] pick_center();
    case ($urandom_range(0, 3))
      0: return 10'($urandom_range(0, 63));
      1: return 10'($urandom_range(960, 1023));
      default: return 10'($urandom_range(0, 1023));
    endcase
  endfunction

  initial begin
    repeat (8) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Directed: zero radius, largest radius, corners, negative wrap
    send_circle(10'd0, 10'd0, 6'd0);
    send_circle(10'd1023, 10'd1023, 6'd0);
    send_circle(10'd0, 10'd0, 6'd63);
    send_circle(10'd1023, 10'd1023, 6'd63);
    send_circle(10'd0, 10'd1023, 6'd63);
    send_circle(10'd1023, 10'd0, 6'd1);
    send_circle(10'd100, 10'd200, 6'd1);
    send_circle(10'd300, 10'd400, 6'd2);
    send_circle(10'd500, 10'd600, 6'd3);
    send_circle(10'd700, 10'd800, 6'd4);
    send_circle(10'd900, 10'd50, 6'd5);
    send_circle(10'd512, 10'd512, 6'd10);
    send_circle(10'd5, 10'd5, 6'd40);
    send_circle(10'd20, 10'd1000, 6'd63);
    send_circle(10'd511, 10'd512, 6'd31);
    send_circle(10'd513, 10'd510, 6'd32);
    send_circle(10'h2AA, 10'h155, 6'h2A);
    send_circle(10'h155, 10'h2AA, 6'h15);
    drain();

    // Random circles; a quiet stretch with no idling, a drain midway
    for (int i = 0; i < RandomItems; i++) begin
      if (i == 40) steady <= 1'b1;
      if (i == 75) steady <= 1'b0;
      if (i == 120) drain();
      send_circle(pick_center(), pick_center(), 6'($urandom_range(0, 63)));
    end
    s_valid <= 1'b0;

    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (SettleCycles) @(posedge clk_i);
    if (sb.pending() != 0) sb.report("steps still outstanding at end of run");

    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: circle_outline_rasterizer_top.f
design/cor_pkg.sv
design/cor_ctrl.sv
design/cor_datapath.sv
design/circle_outline_rasterizer_top.sv
verif/testbench.sv
